// ===== rtl/scale2x_pixel_upscaler_core_assert.svh =====
// Assertion macros for the Scale2x upscaler.
// Synthesis builds define SYNTH and get empty bodies.
`ifndef SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH
`define SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define S2X_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scale2x assertion failed");

// Next-cycle implication
`define S2X_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scale2x assertion failed");

`else

`define S2X_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define S2X_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/s2x_pkg.sv =====
package s2x_pkg;

	typedef logic [15:0] pix_t;
	typedef logic [9:0]  coord_t;

	// Configuration port
	localparam int CFG_DW = 11;
	typedef logic [CFG_DW-1:0] cfg_data_t;
	typedef logic [1:0]        cfg_idx_t;
	localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

	// Blocks one request can produce, in emission order
	localparam int NBLK = 3;
	typedef logic [NBLK-1:0] blk_mask_t;
	typedef logic [1:0]      blk_sel_t;
	localparam blk_sel_t BLK_DELAYED = 2'd0;  // row above, same column
	localparam blk_sel_t BLK_LEFT    = 2'd1;  // last row, one column back
	localparam blk_sel_t BLK_FINAL   = 2'd2;  // last pixel of the frame

	// Work record passed from front to back, neighbors already clamped
	typedef struct packed {
		blk_mask_t mask;
		coord_t    col;
		coord_t    row;
		pix_t      pix;
		pix_t      b0;
		pix_t      d0;
		pix_t      e0;
		pix_t      f0;
		pix_t      b1;
		pix_t      d1;
		pix_t      e1;
		pix_t      b2;
		pix_t      d2;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

endpackage

// ===== rtl/s2x_pixel_if.sv =====
interface s2x_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

// ===== rtl/s2x_block_if.sv =====
interface s2x_block_if;
	logic        valid;
	logic        ready;
	logic [9:0]  src_col;
	logic [9:0]  src_row;
	logic [15:0] top_left;
	logic [15:0] top_right;
	logic [15:0] bottom_left;
	logic [15:0] bottom_right;
	logic        last;

	modport source(output valid, output src_col, output src_row, output top_left,
		output top_right, output bottom_left, output bottom_right, output last,
		input ready);
	modport sink(input valid, input src_col, input src_row, input top_left,
		input top_right, input bottom_left, input bottom_right, input last,
		output ready);
endinterface

// ===== rtl/s2x_ram.sv =====
module s2x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write, one registered read; read data holds between reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/s2x_front.sv =====
module s2x_front import s2x_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  cfg_idx_t       cfg_wr_idx,
	input  cfg_data_t      cfg_wr_data,
	s2x_pixel_if.sink      pixel_in,
	output logic           push,
	output work_t          work,
	input  q_stat_t        q_stat
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int RST_W = (320 > MAX_WIDTH) ? MAX_WIDTH : 320;
	localparam int RST_H = (240 > MAX_HEIGHT) ? MAX_HEIGHT : 240;

	// Frame size, held as last column / last row
	logic [CW-1:0] wlast_q, wlast_d;
	logic [RW-1:0] hlast_q, hlast_d;
	logic          cfg_hit;

	// Position of the next request
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Stage 1: request plus line memory read data
	logic          s1_valid_q;
	pix_t          pix_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          byp_n_s1, byp_o_s1;
	pix_t          byp_n_data_s1, byp_o_data_s1;

	// Running window over the row above, plus the current row's history
	pix_t win_d_q, win_e_q, row0_q;
	pix_t rec0_q, rec1_q;

	logic          accept, s1_adv;
	logic [CW-1:0] n_raddr;
	pix_t          n_rd, o_rd, newer_v, older_v;
	pix_t          cur_d, cur_e, cur_f, cur_b;
	logic          c0, c_ge2, r_ge1, r_ge2, clast, rlast;
	blk_mask_t     mask;

	// Clamp size registers: zero acts as one, large values as the maximum
	always_comb begin
		if (cfg_wr_data == '0) begin
			wlast_d = '0;
			hlast_d = '0;
		end else begin
			wlast_d = (int'(cfg_wr_data) > MAX_WIDTH) ? CW'(MAX_WIDTH - 1)
				: CW'(cfg_wr_data - 1'b1);
			hlast_d = (int'(cfg_wr_data) > MAX_HEIGHT) ? RW'(MAX_HEIGHT - 1)
				: RW'(cfg_wr_data - 1'b1);
		end
	end

	assign cfg_hit = cfg_wr_en &&
		(cfg_wr_idx == REG_FRAME_WIDTH || cfg_wr_idx == REG_FRAME_HEIGHT);

	assign s1_adv         = s1_valid_q && (mask == '0 || !q_stat.full);
	assign pixel_in.ready = !s1_valid_q || s1_adv;
	assign accept         = pixel_in.valid && pixel_in.ready;
	assign push           = s1_adv && (mask != '0);

	// Line memories: newer holds row r-1, older row r-2
	assign n_raddr = col_q + CW'(1);

	s2x_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_newer (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_en   (accept),
		.rd_addr (n_raddr),
		.rd_data (n_rd)
	);

	s2x_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_older (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (cur_e),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (o_rd)
	);

	// Control: size, position, stage valid, recent pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q    <= CW'(RST_W - 1);
			hlast_q    <= RW'(RST_H - 1);
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
			rec0_q     <= '0;
			rec1_q     <= '0;
		end else begin
			if (cfg_hit) begin
				if (cfg_wr_idx == REG_FRAME_WIDTH) begin
					wlast_q <= wlast_d;
				end else begin
					hlast_q <= hlast_d;
				end
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_q == wlast_q) begin
					col_q <= '0;
					row_q <= (row_q == hlast_q) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rec0_q <= pix_s1;
				rec1_q <= rec0_q;
			end
		end
	end

	// Stage 1 payload; forward a line write that hits the address being read
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1        <= pixel_in.pixel;
			col_s1        <= col_q;
			row_s1        <= row_q;
			byp_n_s1      <= s1_adv && (col_s1 == n_raddr);
			byp_o_s1      <= s1_adv && (col_s1 == col_q);
			byp_n_data_s1 <= pix_s1;
			byp_o_data_s1 <= cur_e;
		end
		if (s1_adv) begin
			win_d_q <= cur_e;
			win_e_q <= newer_v;
			if (c0) begin
				row0_q <= pix_s1;
			end
		end
	end

	// Neighbors from the row above
	always_comb begin
		newer_v = byp_n_s1 ? byp_n_data_s1 : n_rd;
		older_v = byp_o_s1 ? byp_o_data_s1 : o_rd;
		c0      = (col_s1 == '0);
		c_ge2   = (col_s1 > CW'(1));
		r_ge1   = (row_s1 != '0);
		r_ge2   = (row_s1 > RW'(1));
		clast   = (col_s1 == wlast_q);
		rlast   = (row_s1 == hlast_q);
		cur_e   = c0 ? row0_q : win_e_q;
		cur_d   = c0 ? cur_e : win_d_q;
		cur_f   = clast ? cur_e : newer_v;
		cur_b   = r_ge2 ? older_v : cur_e;
	end

	// Classify: which blocks this request releases
	always_comb begin
		mask              = '0;
		mask[BLK_DELAYED] = r_ge1;
		mask[BLK_LEFT]    = rlast && !c0;
		mask[BLK_FINAL]   = rlast && clast;

		work      = '0;
		work.mask = mask;
		work.col  = coord_t'(col_s1);
		work.row  = coord_t'(row_s1);
		work.pix  = pix_s1;
		work.b0   = cur_b;
		work.d0   = cur_d;
		work.e0   = cur_e;
		work.f0   = cur_f;
		work.e1   = rec0_q;
		work.d1   = c_ge2 ? rec1_q : rec0_q;
		work.b1   = r_ge1 ? cur_d : rec0_q;
		work.d2   = c0 ? pix_s1 : rec0_q;
		work.b2   = r_ge1 ? cur_e : pix_s1;
	end

endmodule

// ===== rtl/s2x_queue.sv =====
module s2x_queue import s2x_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  work_t   wr,
	input  logic    pop,
	output work_t   rd,
	output q_stat_t stat
);

	work_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QCW-1:0]   cnt_q;

	assign rd         = mem_q[rp_q];
	assign stat.full  = (cnt_q == QCW'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr;
		end
	end

endmodule

// ===== rtl/s2x_back.sv =====
module s2x_back import s2x_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  work_t       head,
	input  q_stat_t     q_stat,
	output logic        pop,
	s2x_block_if.source block_out
);

	typedef struct packed {
		pix_t tl;
		pix_t tr;
		pix_t bl;
		pix_t br;
	} quad_t;

	blk_mask_t done_q, pend, sel_bit;
	blk_sel_t  sel;
	logic      is_last, fire;
	pix_t      nb, nd, ne, nf, nh;
	coord_t    ncol, nrow;
	quad_t     quad;

	logic      out_valid_q;
	coord_t    col_q, row_q;
	quad_t     quad_q;
	logic      last_q;

	// Scale2x rule for one 2x2 block
	function automatic quad_t epx(pix_t b, pix_t d, pix_t e, pix_t f, pix_t h);
		quad_t q;
		q.tl = (d == b && b != f && d != h) ? d : e;
		q.tr = (b == f && b != d && f != h) ? f : e;
		q.bl = (d == h && d != b && h != f) ? d : e;
		q.br = (h == f && d != h && b != f) ? f : e;
		return q;
	endfunction

	// Pick the next pending block of the head entry
	always_comb begin
		pend = head.mask & ~done_q;
		if (pend[BLK_DELAYED]) begin
			sel = BLK_DELAYED;
		end else if (pend[BLK_LEFT]) begin
			sel = BLK_LEFT;
		end else begin
			sel = BLK_FINAL;
		end
		sel_bit = blk_mask_t'(1) << sel;
		is_last = ((pend & ~sel_bit) == '0);
		fire    = !q_stat.empty && (!out_valid_q || block_out.ready);
		pop     = fire && is_last;
	end

	// Neighbor set of the selected block
	always_comb begin
		case (sel)
			BLK_DELAYED: begin
				nb = head.b0; nd = head.d0; ne = head.e0; nf = head.f0; nh = head.pix;
				ncol = head.col;
				nrow = head.row - coord_t'(1);
			end
			BLK_LEFT: begin
				nb = head.b1; nd = head.d1; ne = head.e1; nf = head.pix; nh = head.e1;
				ncol = head.col - coord_t'(1);
				nrow = head.row;
			end
			default: begin
				nb = head.b2; nd = head.d2; ne = head.pix; nf = head.pix; nh = head.pix;
				ncol = head.col;
				nrow = head.row;
			end
		endcase
		quad = epx(nb, nd, ne, nf, nh);
	end

	// Progress through the head entry and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				done_q <= is_last ? '0 : (done_q | sel_bit);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (block_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			col_q  <= ncol;
			row_q  <= nrow;
			quad_q <= quad;
			last_q <= is_last;
		end
	end

	assign block_out.valid        = out_valid_q;
	assign block_out.src_col      = col_q;
	assign block_out.src_row      = row_q;
	assign block_out.top_left     = quad_q.tl;
	assign block_out.top_right    = quad_q.tr;
	assign block_out.bottom_left  = quad_q.bl;
	assign block_out.bottom_right = quad_q.br;
	assign block_out.last         = last_q;

endmodule

// ===== rtl/scale2x_pixel_upscaler_core.sv =====
// Scale2x upscaler: one source pixel per cycle in, one 2x2 block per cycle out, while not stalled.
// A block passes through the queue and then the output register before it is valid at the output.
// Input takes one pixel per cycle while the queue has room; on the last row the output register sets
// the pace at one block per cycle, most pixels there releasing two blocks and the final pixel three.
// Reset: counters, queue and output clear, size returns to 320x240;
// line memories are not cleared and need no clearing pass.
`include "scale2x_pixel_upscaler_core_assert.svh"

module scale2x_pixel_upscaler_core import s2x_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  cfg_idx_t    cfg_wr_idx,
	input  cfg_data_t   cfg_wr_data,
	s2x_pixel_if.sink   pixel_in,
	s2x_block_if.source block_out
);

	logic    q_push, q_pop;
	work_t   q_wr, q_rd;
	q_stat_t q_stat;

	// Front: accept, line memories, classify
	s2x_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_idx  (cfg_wr_idx),
		.cfg_wr_data (cfg_wr_data),
		.pixel_in    (pixel_in),
		.push        (q_push),
		.work        (q_wr),
		.q_stat      (q_stat)
	);

	// Decoupling queue
	s2x_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.stat   (q_stat)
	);

	// Back: expand entries into blocks
	s2x_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rd),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.block_out (block_out)
	);

	// Checks
	`S2X_ASSERT_IMP(a_queue_no_overflow, clk, arst_n, q_push, !q_stat.full)
	`S2X_ASSERT_IMP(a_queue_no_underflow, clk, arst_n, q_pop, !q_stat.empty)
	`S2X_ASSERT_IMP(a_push_has_block, clk, arst_n, q_push, q_wr.mask != '0)
	`S2X_ASSERT_NXT(a_push_fills_queue, clk, arst_n, q_push && q_stat.empty, !q_stat.empty)

endmodule
